// ----- hw/rtl/int128_divider_top_macros.svh -----
// Assertion macros for the int128 divider checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef INT128_DIVIDER_TOP_MACROS_SVH
`define INT128_DIVIDER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define I128D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define I128D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/i128d_pkg.sv -----
// Shared types and constants for the int128 divider.
// No dependencies.
`default_nettype none

package i128d_pkg;

  localparam int unsigned HALF_BITS     = 64;
  localparam int unsigned FULL_BITS     = 128;
  localparam int unsigned WORD_BITS_DEF = 128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i128d_ctrl.sv -----
// Sequencer for the int128 divider: state machine, step counter, output valid.
// Depends on i128d_pkg.
`default_nettype none

module i128d_ctrl #(
  parameter int unsigned WORD_BITS = i128d_pkg::WORD_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output i128d_pkg::dp_cmd_t     cmd_o
);
  import i128d_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load) begin
      cnt_d = CntW'(WORD_BITS - 1);
    end else if (cmd_o.step) begin
      cnt_d = cnt_q - 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/i128d_datapath.sv -----
// Datapath for the int128 divider: operand magnitudes, shift-subtract loop,
// sign fix-up and the output register. Depends on i128d_pkg.
`default_nettype none

module i128d_datapath #(
  parameter int unsigned WORD_BITS = i128d_pkg::WORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire i128d_pkg::dp_cmd_t                 cmd_i,
  input  wire logic [i128d_pkg::FULL_BITS-1:0]    dividend_i,
  input  wire logic [i128d_pkg::FULL_BITS-1:0]    divisor_i,
  input  wire logic                               is_signed_i,
  output logic      [i128d_pkg::FULL_BITS-1:0]    quotient_o,
  output logic      [i128d_pkg::FULL_BITS-1:0]    remainder_o,
  output logic                                    divide_by_zero_o
);
  import i128d_pkg::*;

  localparam int unsigned W = WORD_BITS;

  logic [W-1:0] a, b, mag_a, mag_b;
  logic         a_neg, b_neg, b_zero;

  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, div_q;
  logic         neg_quo_q, neg_rem_q, dz_q;
  logic [W:0]   shifted, diff;
  logic         fits;

  logic [W-1:0] res_quo_q, res_rem_q, fix_quo, fix_rem;
  logic         res_dz_q;

  // Operand magnitudes; a zero divisor keeps the raw dividend.
  assign a      = dividend_i[W-1:0];
  assign b      = divisor_i[W-1:0];
  assign b_zero = (b == '0);
  assign a_neg  = is_signed_i && a[W-1] && !b_zero;
  assign b_neg  = is_signed_i && b[W-1];
  assign mag_a  = a_neg ? (~a + 1'b1) : a;
  assign mag_b  = b_neg ? (~b + 1'b1) : b;

  // One quotient bit per step.
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = !diff[W];
  assign rem_d   = fits ? diff[W-1:0] : shifted[W-1:0];
  assign quo_d   = {quo_q[W-2:0], fits};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q     <= '0;
      quo_q     <= mag_a;
      div_q     <= mag_b;
      dz_q      <= b_zero;
      neg_quo_q <= (a_neg ^ b_neg) && !b_zero;
      neg_rem_q <= a_neg;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Sign fix-up on the way into the output register.
  assign fix_quo = dz_q ? '0 : (neg_quo_q ? (~quo_q + 1'b1) : quo_q);
  assign fix_rem = neg_rem_q ? (~rem_q + 1'b1) : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_quo_q <= fix_quo;
      res_rem_q <= fix_rem;
      res_dz_q  <= dz_q;
    end
  end

  always_comb begin
    quotient_o           = '0;
    quotient_o[W-1:0]    = res_quo_q;
    remainder_o          = '0;
    remainder_o[W-1:0]   = res_rem_q;
  end

  assign divide_by_zero_o = res_dz_q;

endmodule

`default_nettype wire

// ----- hw/rtl/int128_divider_top.sv -----
// Top level of the int128 divider: signed/unsigned restoring division.
// Instantiates i128d_ctrl and i128d_datapath; depends on i128d_pkg.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | dividend_hi/lo, divisor_hi/lo, is_signed
//  out     | output    | out_valid_o / out_ready_i| quotient_hi/lo, remainder_hi/lo, divide_by_zero
//
// Sequencing: once a transaction is accepted, the datapath loop runs one subtract-and-shift
//   step per quotient bit, then sign fix-up moves the result into the output register.
// The next input is taken as soon as the result sits in the output register, so a new
//   item is not accepted while the previous one is still being computed.
// A stalled consumer holds the result; the following item computes and then
//   waits in the final state until the output register frees up.
// Reset (rst_ni, asynchronous, active low) clears the controller; payload registers
//   carry no reset.
`default_nettype none

module int128_divider_top #(
  parameter int unsigned WORD_BITS = i128d_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [i128d_pkg::HALF_BITS-1:0]   dividend_hi_i,
  input  wire logic [i128d_pkg::HALF_BITS-1:0]   dividend_lo_i,
  input  wire logic [i128d_pkg::HALF_BITS-1:0]   divisor_hi_i,
  input  wire logic [i128d_pkg::HALF_BITS-1:0]   divisor_lo_i,
  input  wire logic                              is_signed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [i128d_pkg::HALF_BITS-1:0]   quotient_hi_o,
  output logic      [i128d_pkg::HALF_BITS-1:0]   quotient_lo_o,
  output logic      [i128d_pkg::HALF_BITS-1:0]   remainder_hi_o,
  output logic      [i128d_pkg::HALF_BITS-1:0]   remainder_lo_o,
  output logic                                   divide_by_zero_o
);
  import i128d_pkg::*;

  dp_cmd_t              cmd;
  logic [FULL_BITS-1:0] quotient, remainder;

  // Sequence the transaction: accept, iterate, fix up, hand over.
  i128d_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Operands arrive as 64-bit halves; join them into full words here.
  i128d_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .dividend_i       ({dividend_hi_i, dividend_lo_i}),
    .divisor_i        ({divisor_hi_i, divisor_lo_i}),
    .is_signed_i      (is_signed_i),
    .quotient_o       (quotient),
    .remainder_o      (remainder),
    .divide_by_zero_o (divide_by_zero_o)
  );

  // Split results back into halves.
  assign quotient_hi_o  = quotient[FULL_BITS-1:HALF_BITS];
  assign quotient_lo_o  = quotient[HALF_BITS-1:0];
  assign remainder_hi_o = remainder[FULL_BITS-1:HALF_BITS];
  assign remainder_lo_o = remainder[HALF_BITS-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/i128d_checker.sv -----
// Port-level assertions for int128_divider_top, attached by bind.
// Depends on i128d_pkg and int128_divider_top_macros.svh.
`default_nettype none
`include "int128_divider_top_macros.svh"

module i128d_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [i128d_pkg::HALF_BITS-1:0]   quotient_hi_o,
  input wire logic [i128d_pkg::HALF_BITS-1:0]   quotient_lo_o,
  input wire logic [i128d_pkg::HALF_BITS-1:0]   remainder_hi_o,
  input wire logic [i128d_pkg::HALF_BITS-1:0]   remainder_lo_o,
  input wire logic                              divide_by_zero_o
);

  // Hold a stalled result.
  `I128D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out_valid dropped while stalled")
  `I128D_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(quotient_hi_o) && $stable(quotient_lo_o) && $stable(remainder_hi_o) && $stable(remainder_lo_o), "result changed while stalled")
  // The divider is busy right after taking a transaction.
  `I128D_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready while busy")
  // A zero divisor always yields a zero quotient.
  `I128D_ASSERT(a_dz_zero_quo, out_valid_o && divide_by_zero_o |-> quotient_hi_o == '0 && quotient_lo_o == '0, "nonzero quotient on zero divisor")

endmodule

bind int128_divider_top i128d_checker u_i128d_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for int128_divider_top: signed and unsigned 128-bit division.
// Drives a directed table, then random operands, and checks quotient, remainder and
// the divide-by-zero flag against an in-bench divider. Depends on i128d_pkg.
`timescale 1ns / 1ps

module testbench;

  import i128d_pkg::*;

  localparam int unsigned W          = FULL_BITS;
  localparam int unsigned H          = HALF_BITS;
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned LATENCY    = WORD_BITS_DEF + 2;
  localparam int unsigned N_RANDOM   = 1580;
  localparam int unsigned TAIL       = 150;
  localparam longint      MAX_CYCLE  = longint'(N_RANDOM + 40) * (LATENCY + 30) * 4;

  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  typedef struct {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         div_zero;
  } div_result_t;

  typedef struct {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         sgn;
    bit           typed;
    div_result_t  want;
  } div_row_t;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_valid    = 1'b0;
  logic         in_ready;
  logic [H-1:0] dividend_hi = '0;
  logic [H-1:0] dividend_lo = '0;
  logic [H-1:0] divisor_hi  = '0;
  logic [H-1:0] divisor_lo  = '0;
  logic         is_signed   = 1'b0;
  logic         out_valid;
  logic         out_ready   = 1'b0;
  logic [H-1:0] quotient_hi;
  logic [H-1:0] quotient_lo;
  logic [H-1:0] remainder_hi;
  logic [H-1:0] remainder_lo;
  logic         divide_by_zero;

  div_result_t  pending_results[$];
  div_row_t     directed_rows[$];
  int unsigned  error_count = 0;
  longint       cycle_count = 0;
  bit           quiet_tail  = 0;

  int128_divider_top #(
    .WORD_BITS (WORD_BITS_DEF)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .dividend_hi_i    (dividend_hi),
    .dividend_lo_i    (dividend_lo),
    .divisor_hi_i     (divisor_hi),
    .divisor_lo_i     (divisor_lo),
    .is_signed_i      (is_signed),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .quotient_hi_o    (quotient_hi),
    .quotient_lo_o    (quotient_lo),
    .remainder_hi_o   (remainder_hi),
    .remainder_lo_o   (remainder_lo),
    .divide_by_zero_o (divide_by_zero)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report(input string msg);
    error_count++;
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
  endtask

  // Divide magnitudes, then fix the signs: truncate toward zero, remainder
  // follows the dividend. A zero divisor gives a zero quotient and the dividend.
  function automatic div_result_t predict(input logic [W-1:0] dvd,
                                          input logic [W-1:0] dvs,
                                          input logic         sgn);
    div_result_t  r;
    logic         a_neg;
    logic         b_neg;
    logic [W-1:0] ua;
    logic [W-1:0] ub;
    logic [W-1:0] q;
    logic [W-1:0] m;
    r.div_zero = (dvs == '0);
    if (r.div_zero) begin
      r.quotient  = '0;
      r.remainder = dvd;
    end else if (!sgn) begin
      r.quotient  = dvd / dvs;
      r.remainder = dvd % dvs;
    end else begin
      a_neg = dvd[W-1];
      b_neg = dvs[W-1];
      ua    = a_neg ? (~dvd + 1'b1) : dvd;
      ub    = b_neg ? (~dvs + 1'b1) : dvs;
      q     = ua / ub;
      m     = ua % ub;
      r.quotient  = (a_neg != b_neg) ? (~q + 1'b1) : q;
      r.remainder = a_neg ? (~m + 1'b1) : m;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [W-1:0] dvd, input logic [W-1:0] dvs,
                                  input logic sgn, input bit typed,
                                  input logic [W-1:0] q, input logic [W-1:0] r,
                                  input logic dz);
    div_row_t row;
    row.dividend       = dvd;
    row.divisor        = dvs;
    row.sgn            = sgn;
    row.typed          = typed;
    row.want.quotient  = q;
    row.want.remainder = r;
    row.want.div_zero  = dz;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_rows();
    // Zero divisor in both modes: zero quotient, dividend comes back.
    add_row('0, '0, 1'b0, 1'b1, '0, '0, 1'b1);
    add_row(W'(12345), '0, 1'b1, 1'b1, '0, W'(12345), 1'b1);
    add_row(MOST_NEG, '0, 1'b1, 1'b1, '0, MOST_NEG, 1'b1);
    add_row(ALL_ONES, '0, 1'b0, 1'b1, '0, ALL_ONES, 1'b1);
    // Most negative by minus one wraps.
    add_row(MOST_NEG, ALL_ONES, 1'b1, 1'b1, MOST_NEG, '0, 1'b0);
    add_row(ALL_ONES, W'(1), 1'b0, 1'b1, ALL_ONES, '0, 1'b0);
    add_row(ALL_ONES, ALL_ONES, 1'b0, 1'b1, W'(1), '0, 1'b0);
    add_row(W'(5), W'(7), 1'b0, 1'b1, '0, W'(5), 1'b0);
    // Minus one by two truncates to zero, remainder minus one.
    add_row(ALL_ONES, W'(2), 1'b1, 1'b1, '0, ALL_ONES, 1'b0);
    add_row('0, W'(3), 1'b1, 1'b1, '0, '0, 1'b0);
    // Sign combinations (~6 is minus seven, ~1 is minus two).
    add_row(~W'(6), W'(2), 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(W'(7), ~W'(1), 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(~W'(6), ~W'(1), 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(MOST_POS, MOST_NEG, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(MOST_NEG, MOST_NEG, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(MOST_NEG, W'(1), 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(MOST_NEG, W'(2), 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(ALL_ONES, MOST_NEG, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(MOST_POS, W'(3), 1'b0, 1'b0, '0, '0, 1'b0);
    add_row({64'h0123456789abcdef, 64'hfedcba9876543210}, W'(64'h00000000deadbeef),
            1'b0, 1'b0, '0, '0, 1'b0);
    add_row({64'hfedcba9876543210, 64'h0123456789abcdef}, W'(64'h0000000012345679),
            1'b1, 1'b0, '0, '0, 1'b0);
  endfunction

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = ALL_ONES;
      2:       v = MOST_NEG;
      3:       v = MOST_POS;
      4, 5:    v = v >> $urandom_range(0, W - 1);
      6:       v = ~(v >> $urandom_range(0, W - 1));
      default: v = v;
    endcase
    return v;
  endfunction

  // Present one transaction and hold it until it is taken.
  task automatic drive_item(input logic [W-1:0] dvd, input logic [W-1:0] dvs,
                            input logic sgn, input div_result_t want);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    dividend_hi <= dvd[W-1:H];
    dividend_lo <= dvd[H-1:0];
    divisor_hi  <= dvs[W-1:H];
    divisor_lo  <= dvs[H-1:0];
    is_signed   <= sgn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_result();
    div_result_t want;
    if (pending_results.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    want = pending_results.pop_front();
    if ({quotient_hi, quotient_lo} !== want.quotient ||
        {remainder_hi, remainder_lo} !== want.remainder ||
        divide_by_zero !== want.div_zero) begin
      report($sformatf("q %h%h r %h%h dz %b, want q %h r %h dz %b",
                       quotient_hi, quotient_lo, remainder_hi, remainder_lo,
                       divide_by_zero, want.quotient, want.remainder, want.div_zero));
    end
  endtask

  initial begin : driver
    div_row_t     row;
    div_result_t  want;
    logic [W-1:0] dvd;
    logic [W-1:0] dvs;
    logic         sgn;
    build_rows();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.typed ? row.want : predict(row.dividend, row.divisor, row.sgn);
      drive_item(row.dividend, row.divisor, row.sgn, want);
    end
    drain();
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - TAIL) quiet_tail = 1'b1;
      if (i == N_RANDOM / 2) drain();
      dvd = pick_operand();
      dvs = pick_operand();
      sgn = logic'($urandom_range(0, 1));
      drive_item(dvd, dvs, sgn, predict(dvd, dvs, sgn));
    end
    drain();
    repeat (5) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Take results, with random bursts of back pressure outside the tail.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result();
      if (quiet_tail) begin
        out_ready <= 1'b1;
      end else if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLE) begin
      report("cycle limit reached");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
